@@ rtl/aui_pkg.sv @@
// Shared types and constants for the H.264 access unit inspector.
package aui_pkg;

   localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
   localparam logic [4:0] NAL_IDR       = 5'd5;
   localparam logic [4:0] NAL_SPS       = 5'd7;
   localparam logic [4:0] NAL_PPS       = 5'd8;

   localparam logic [1:0] SPS_BYTES     = 2'd3;
   localparam int         RSP_WIDTH     = 32;

   typedef struct packed {
      logic       start_code_seen;
      logic       idr_seen;
      logic       sps_seen;
      logic       pps_seen;
      logic       profile_valid;
      logic [7:0] profile_idc;
      logic [7:0] constraint_flags;
      logic [7:0] level_idc;
      logic       frame_is_idr;
   } summary_type;

endpackage

@@ rtl/aui_scan.sv @@
// Start code scanner, NAL type flags and SPS profile capture for one access unit.
module aui_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic                 idr_hint,
   output aui_pkg::summary_type summary
);

   logic [1:0]  zero_run_ff,      zero_run_in;
   logic        awaiting_ff,      awaiting_in;
   logic [1:0]  capture_left_ff,  capture_left_in;
   logic [23:0] capture_shift_ff, capture_shift_in;
   logic        start_ff,         start_in;
   logic        idr_ff,           idr_in;
   logic        sps_ff,           sps_in;
   logic        pps_ff,           pps_in;
   logic        prof_valid_ff,    prof_valid_in;
   logic [23:0] prof_data_ff,     prof_data_in;
   logic [4:0]  nal_type;

   assign nal_type = 5'(data_byte & aui_pkg::NAL_TYPE_MASK);

   always_comb begin
      zero_run_in      = zero_run_ff;
      awaiting_in      = awaiting_ff;
      capture_left_in  = capture_left_ff;
      capture_shift_in = capture_shift_ff;
      start_in         = start_ff;
      idr_in           = idr_ff;
      sps_in           = sps_ff;
      pps_in           = pps_ff;
      prof_valid_in    = prof_valid_ff;
      prof_data_in     = prof_data_ff;

      // The capture shifts alongside scanning, so SPS bytes are scanned too.
      if (capture_left_ff != 2'd0) begin
         capture_shift_in = {capture_shift_ff[15:0], data_byte};
         capture_left_in  = capture_left_ff - 2'd1;
         if (capture_left_in == 2'd0) begin
            prof_valid_in = 1'b1;
            prof_data_in  = capture_shift_in;
         end
      end

      if (awaiting_ff) begin
         awaiting_in = 1'b0;
         zero_run_in = 2'd0;
         start_in    = 1'b1;
         unique case (nal_type)
            aui_pkg::NAL_IDR: idr_in = 1'b1;
            aui_pkg::NAL_SPS: begin
               sps_in = 1'b1;
               // Only the first SPS whose three bytes all arrive is kept.
               if (capture_left_in == 2'd0 && !prof_valid_in) begin
                  capture_left_in  = aui_pkg::SPS_BYTES;
                  capture_shift_in = '0;
               end
            end
            aui_pkg::NAL_PPS: pps_in = 1'b1;
            default: ;
         endcase
      end else if (data_byte == 8'h00) begin
         if (zero_run_ff != 2'd2) begin
            zero_run_in = zero_run_ff + 2'd1;
         end
      end else if (data_byte == 8'h01 && zero_run_ff == 2'd2) begin
         awaiting_in = 1'b1;
         zero_run_in = 2'd0;
      end else begin
         zero_run_in = 2'd0;
      end
   end

   always_comb begin
      summary.start_code_seen  = start_in;
      summary.idr_seen         = idr_in;
      summary.sps_seen         = sps_in;
      summary.pps_seen         = pps_in;
      summary.profile_valid    = prof_valid_in;
      summary.profile_idc      = prof_valid_in ? prof_data_in[23:16] : 8'h00;
      summary.constraint_flags = prof_valid_in ? prof_data_in[15:8]  : 8'h00;
      summary.level_idc        = prof_valid_in ? prof_data_in[7:0]   : 8'h00;
      summary.frame_is_idr     = start_in ? idr_in : idr_hint;
   end

   // The last byte of an access unit resets all control state.
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         zero_run_ff     <= 2'd0;
         awaiting_ff     <= 1'b0;
         capture_left_ff <= 2'd0;
         start_ff        <= 1'b0;
         idr_ff          <= 1'b0;
         sps_ff          <= 1'b0;
         pps_ff          <= 1'b0;
         prof_valid_ff   <= 1'b0;
      end else if (step) begin
         zero_run_ff     <= zero_run_in;
         awaiting_ff     <= awaiting_in;
         capture_left_ff <= capture_left_in;
         start_ff        <= start_in;
         idr_ff          <= idr_in;
         sps_ff          <= sps_in;
         pps_ff          <= pps_in;
         prof_valid_ff   <= prof_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         capture_shift_ff <= capture_shift_in;
         prof_data_ff     <= prof_data_in;
      end
   end

endmodule

@@ rtl/h264_access_unit_inspector.sv @@
// Top level of the H.264 access unit inspector: input register, scanner and result register.
//
//   Channel  Direction  Carries
//   req_     in         one byte of an access unit; tlast marks its final byte, tuser the IDR hint
//   rsp_     out        one summary transaction per access unit, sent after its final byte
//
// One byte per cycle is sustained unless a waiting summary holds back a final byte: a byte
// waits in the input register, then the scanner updates its state from it while, on the final
// byte, the summary is loaded into the result register. Reset is synchronous and clears all
// control state. A waiting summary stalls only the next final byte and the bytes behind it.
module h264_access_unit_inspector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // idr_hint
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] start_code_seen, [1] idr_seen, [2] sps_seen, [3] pps_seen, [4] profile_valid,
   // [12:5] profile_idc, [20:13] constraint_flags, [28:21] level_idc, [29] frame_is_idr,
   // [31:30] zero
   output logic [31:0] rsp_tdata
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 in_hint_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;
   logic                 out_free;
   logic                 step;
   aui_pkg::summary_type summary;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
         in_hint_ff <= req_tuser;
      end
   end

   aui_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .idr_hint  (in_hint_ff),
      .summary   (summary)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_data_ff <= {2'b00,
                         summary.frame_is_idr,
                         summary.level_idc,
                         summary.constraint_flags,
                         summary.profile_idc,
                         summary.profile_valid,
                         summary.pps_seen,
                         summary.sps_seen,
                         summary.idr_seen,
                         summary.start_code_seen};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff[aui_pkg::RSP_WIDTH-1:0];

endmodule
